@@ rtl/core/toeq_pkg.sv @@
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

    // Default number of stored events
    localparam int QUEUE_DEPTH_DEF = 32;

    // Stream payload widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;
    localparam int OCC_W      = 6;

    // Command carried on the input tuser
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // Status carried on the output tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Event kind that counts toward the pending-departure flag
    localparam logic [1:0] KIND_DEPARTURE = 2'd1;

    // Host code meaning "no host"
    localparam logic [4:0] HOST_NONE = 5'h1F;

    // One stored event
    typedef struct packed {
        logic [4:0]  dst;
        logic [4:0]  src;
        logic [1:0]  kind;
        logic [47:0] evt_time;
    } entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_REM_RD,
        ST_REM_DATA,
        ST_RESULT
    } state_t;

endpackage

@@ rtl/core/toeq_store.sv @@
// Event storage RAM: one write port and one registered read port.
module toeq_store
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PTR_W       = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [PTR_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one entry, data valid the next cycle
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/time_ordered_event_queue.sv @@
// Top level of the time-ordered event queue: sequencer, ring pointers and stream ports.
//
// Events are kept in a ring buffer in a single RAM, sorted earliest first from the
// head pointer. One transaction is processed at a time. The result shows on the
// output in the same cycle that the block is ready again. A remove reads the head
// entry and advances the head. An insert walks from the tail toward the head with
// one shared 48-bit time comparator, moving each later-or-equal entry up one slot.
// Each moved entry passes through the RAM's read-then-write loop, ST_INS_RD then
// ST_INS_CMP. An insert whose walk reaches the head writes the new entry at the
// head; one that stops at an earlier entry writes it in the slot just above it.
// Remove on empty and insert on full go straight to the result. A result waiting
// on the output does not block acceptance of the next transaction. That
// transaction's result then holds in the sequencer, with the input not ready,
// until the output frees.
module time_ordered_event_queue
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [47:0] event_time, [49:48] event_kind, [54:50] source_host,
    // [59:55] dest_host, [63:60] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [47:0] out_time, [49:48] out_kind, [54:50] out_source, [59:55] out_dest,
    // [60] departure_pending, [66:61] occupancy, [71:67] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]            m_tuser
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W:0] DEPTH_W = (PTR_W+1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam entry_t ENTRY_NONE = '{dst: HOST_NONE, src: HOST_NONE, kind: 2'd0,
                                      evt_time: 48'd0};

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      dep_reg, dep_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    entry_t                new_reg, new_next;
    status_t               res_status_reg, res_status_next;
    entry_t                res_entry_reg, res_entry_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    entry_t                wr_data;
    logic [PTR_W-1:0]      rd_addr;
    entry_t                rd_data;

    logic [CNT_W-1:0]      idx_m1;
    logic [PTR_W:0]        sum_cur, sum_prev, sum_head;
    logic [PTR_W-1:0]      slot_cur, slot_prev, head_inc;
    entry_t                in_entry;
    logic                  new_is_dep;
    logic                  later_or_equal;

    // Unpack the input transaction
    assign in_entry.evt_time = s_tdata[47:0];
    assign in_entry.kind     = s_tdata[49:48];
    assign in_entry.src      = s_tdata[54:50];
    assign in_entry.dst      = s_tdata[59:55];
    assign new_is_dep        = (new_reg.kind == KIND_DEPARTURE);

    // Map logical positions to ring slots
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign sum_cur   = {1'b0, head_reg} + (PTR_W+1)'(idx_reg[PTR_W-1:0]);
    assign sum_prev  = {1'b0, head_reg} + (PTR_W+1)'(idx_m1[PTR_W-1:0]);
    assign sum_head  = {1'b0, head_reg} + (PTR_W+1)'(1);
    assign slot_cur  = (sum_cur  >= DEPTH_W) ? PTR_W'(sum_cur  - DEPTH_W) : sum_cur[PTR_W-1:0];
    assign slot_prev = (sum_prev >= DEPTH_W) ? PTR_W'(sum_prev - DEPTH_W) : sum_prev[PTR_W-1:0];
    assign head_inc  = (sum_head >= DEPTH_W) ? PTR_W'(sum_head - DEPTH_W) : sum_head[PTR_W-1:0];

    // Shared time comparator
    assign later_or_equal = (rd_data.evt_time >= new_reg.evt_time);

    toeq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold state and pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            dep_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            dep_reg      <= dep_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // Sequence one transaction
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        dep_next        = dep_reg;
        idx_next        = idx_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_cur;
        wr_data         = new_reg;
        rd_addr         = slot_prev;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_entry_next  = ENTRY_NONE;
                    res_status_next = STAT_OK;
                    if (s_tuser == CMD_INSERT)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            res_status_next = STAT_FULL;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            new_next   = in_entry;
                            idx_next   = count_reg;
                            state_next = ST_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_REM_RD;
                        end
                    end
                end
            end

            ST_INS_RD:
            begin
                // Place at the head when the walk reaches it
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (new_is_dep)
                    begin
                        dep_next = dep_reg + CNT_W'(1);
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (later_or_equal)
                begin
                    // Move the later entry up one slot and keep walking
                    wr_data    = rd_data;
                    idx_next   = idx_m1;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (new_is_dep)
                    begin
                        dep_next = dep_reg + CNT_W'(1);
                    end
                    state_next = ST_RESULT;
                end
            end

            ST_REM_RD:
            begin
                rd_addr    = head_reg;
                state_next = ST_REM_DATA;
            end

            ST_REM_DATA:
            begin
                // Drop the head entry
                res_entry_next = rd_data;
                head_next      = head_inc;
                count_next     = count_reg - CNT_W'(1);
                if (rd_data.kind == KIND_DEPARTURE)
                begin
                    dep_next = dep_reg - CNT_W'(1);
                end
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {5'b0, OCC_W'(count_reg), (dep_reg != '0),
                                     res_entry_reg.dst, res_entry_reg.src,
                                     res_entry_reg.kind, res_entry_reg.evt_time};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Occupancy never exceeds the queue depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("event count above queue depth");

    // Pending departures never exceed the stored events
    assert property (@(posedge clk) disable iff (!rst_n) dep_reg <= count_reg)
        else $error("departure count above event count");

    // A dropped insert reports a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[66:61] == OCC_W'(QUEUE_DEPTH)))
        else $error("full status with queue not full");

    // A later-or-equal compare during an insert steps the walk one entry toward the head
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_CMP && later_or_equal) |=> (idx_reg == $past(idx_m1)))
        else $error("insert walk did not step");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the time-ordered event queue: stream stimulus, sorted-queue predictor, checker.
`timescale 1ns / 100ps

module tb_top
    import toeq_pkg::*;
();

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES = 300;

    // Event kinds that the package does not name
    localparam logic [1:0] KIND_ARRIVAL  = 2'd0;
    localparam logic [1:0] KIND_BACKOFF  = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    // Expected outcome of one queue operation
    typedef struct packed {
        status_t        status;
        entry_t         removed;
        logic           departure;
        logic [OCC_W-1:0] occupancy;
    } queue_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    entry_t         sorted_events[$];
    queue_outcome_t outcome_q[$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    time_ordered_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one operation to the sorted mirror and return what the block must report
    function automatic queue_outcome_t apply_queue_step(input cmd_t cmd, input entry_t ev);
        queue_outcome_t o;
        int pos;
        o.status           = STAT_OK;
        o.removed.evt_time = '0;
        o.removed.kind     = KIND_ARRIVAL;
        o.removed.src      = HOST_NONE;
        o.removed.dst      = HOST_NONE;
        if (cmd == CMD_INSERT)
        begin
            if (sorted_events.size() >= DEPTH)
                o.status = STAT_FULL;
            else
            begin
                // land ahead of the first entry that is not earlier
                pos = 0;
                while (pos < sorted_events.size() && sorted_events[pos].evt_time < ev.evt_time)
                    pos++;
                sorted_events.insert(pos, ev);
            end
        end
        else
        begin
            if (sorted_events.size() == 0)
                o.status = STAT_EMPTY;
            else
                o.removed = sorted_events.pop_front();
        end
        o.departure = 1'b0;
        foreach (sorted_events[i])
            if (sorted_events[i].kind == KIND_DEPARTURE)
                o.departure = 1'b1;
        o.occupancy = OCC_W'(sorted_events.size());
        return o;
    endfunction

    // Timestamp mix: full range, clustered small values for ties, values near the top, values under 2^26
    function automatic logic [47:0] pick_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0: return r[47:0];
            1: return {16'd0, 16'($urandom_range(7)), 16'($urandom_range(1) * 16'h8000)};
            2: return TIME_MAX - 48'($urandom_range(3));
            default: return {32'($urandom_range(1000)), r[15:0]};
        endcase
    endfunction

    function automatic entry_t pick_event();
        entry_t ev;
        ev.evt_time = pick_time();
        ev.kind     = 2'($urandom_range(3));
        ev.src      = 5'($urandom_range(31));
        ev.dst      = 5'($urandom_range(31));
        return ev;
    endfunction

    // Offer one transaction, hold it until accepted, then record its outcome
    task automatic send_event(input cmd_t cmd, input entry_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - $bits(entry_t)){1'b0}}, ev};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        outcome_q.push_back(apply_queue_step(cmd, ev));
    endtask

    task automatic send_fields(input cmd_t cmd, input logic [47:0] t, input logic [1:0] k,
                               input logic [4:0] src, input logic [4:0] dst);
        entry_t ev;
        ev.evt_time = t;
        ev.kind     = k;
        ev.src      = src;
        ev.dst      = dst;
        send_event(cmd, ev);
    endtask

    // Field extremes, every kind, equal times, remove on empty
    task automatic test_directed();
        send_fields(CMD_REMOVE, '0, KIND_ARRIVAL, HOST_NONE, HOST_NONE);
        send_fields(CMD_INSERT, TIME_MAX, KIND_ARRIVAL, HOST_NONE, 5'd15);
        send_fields(CMD_INSERT, '0, KIND_DEPARTURE, 5'h10, 5'd0);
        send_fields(CMD_INSERT, 48'h5_8000, KIND_BACKOFF, 5'd0, HOST_NONE);
        send_fields(CMD_INSERT, 48'h5_8000, KIND_RESERVED, 5'd15, 5'h10);
        send_fields(CMD_INSERT, 48'h5_8000, KIND_DEPARTURE, 5'd1, 5'd2);
        send_fields(CMD_INSERT, TIME_MAX, KIND_RESERVED, 5'h0A, 5'h15);
        send_fields(CMD_INSERT, 48'hAAAA_5555_AAAA, KIND_BACKOFF, 5'h0A, 5'h15);
        send_fields(CMD_INSERT, 48'h5555_AAAA_5555, KIND_ARRIVAL, 5'h15, 5'h0A);
        repeat (9)
            send_fields(CMD_REMOVE, TIME_MAX, KIND_RESERVED, 5'h1F, 5'h1F);
        send_fields(CMD_INSERT, 48'h1_0000, KIND_DEPARTURE, 5'd3, 5'd4);
        send_fields(CMD_REMOVE, '0, KIND_ARRIVAL, HOST_NONE, HOST_NONE);
    endtask

    // Fill to capacity, insert on full, then drain past empty
    task automatic test_overflow();
        while (sorted_events.size() < DEPTH)
            send_event(CMD_INSERT, pick_event());
        repeat (2)
            send_event(CMD_INSERT, pick_event());
        while (sorted_events.size() > 0)
            send_event(CMD_REMOVE, pick_event());
        send_event(CMD_REMOVE, pick_event());
    endtask

    // Random mix whose insert bias drifts so occupancy sweeps between empty and full
    task automatic test_random_traffic(input int n_items);
        int bias;
        bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
                bias = $urandom_range(15, 85);
            if ($urandom_range(99) < bias)
                send_event(CMD_INSERT, pick_event());
            else
                send_event(CMD_REMOVE, pick_event());
        end
    endtask

    // Stall the output for a long stretch while the input keeps offering work
    task automatic test_backpressure();
        hold_seq++;
        for (int i = 0; i < 24; i++)
            send_event((i % 3 == 2) ? CMD_REMOVE : CMD_INSERT, pick_event());
    endtask

    // Output ready: random idling, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [47:0] expv,
                               input logic [47:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, expv, actv);
            error_count++;
        end
    endtask

    // Compare each result transaction with the oldest expected outcome
    always @(posedge clk)
    begin : result_check
        queue_outcome_t exp_o;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                exp_o = outcome_q.pop_front();
                check_field("status", 48'(exp_o.status), 48'(m_tuser));
                check_field("out_time", exp_o.removed.evt_time, m_tdata[47:0]);
                check_field("out_kind", 48'(exp_o.removed.kind), 48'(m_tdata[49:48]));
                check_field("out_source", 48'(exp_o.removed.src), 48'(m_tdata[54:50]));
                check_field("out_dest", 48'(exp_o.removed.dst), 48'(m_tdata[59:55]));
                check_field("departure_pending", 48'(exp_o.departure), 48'(m_tdata[60]));
                check_field("occupancy", 48'(exp_o.occupancy), 48'(m_tdata[66:61]));
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL time_ordered_event_queue");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 19;
        recv_idle_pct = 60;
        test_directed();
        test_random_traffic(110);

        // roles swapped
        send_idle_pct = 60;
        recv_idle_pct = 19;
        test_overflow();
        test_random_traffic(110);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(110);
        test_backpressure();

        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (error_count == 0)
            $display("PASS time_ordered_event_queue");
        else
            $display("FAIL time_ordered_event_queue");
        $finish;
    end

endmodule
